// ===== design/hafp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_pkg
// Shared widths, register codes, configuration record, sequencer states and
// multiply-accumulate request type for the hybrid axis force PI loop.
// ----------------------------------------------------------------------------
package hafp_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PERIOD_W  = 24;
    localparam int unsigned ALPHA_W   = 16;
    localparam int unsigned LIMIT_W   = 31;
    localparam int unsigned REG_IDX_W = 3;

    // shared multiplier: 33 x 33 signed, accumulator holds four products
    localparam int unsigned OP_W   = DATA_W + 1;
    localparam int unsigned PROD_W = 2 * OP_W;
    localparam int unsigned ACC_W  = PROD_W + 2;

    localparam logic [ALPHA_W:0] ALPHA_MAX = 17'd65470;
    localparam logic [ALPHA_W:0] ALPHA_ONE = 17'd65536;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_VEL_DAMPING  = 3'd2,
        REG_FF_GAIN      = 3'd3,
        REG_INTEG_LIMIT  = 3'd4,
        REG_OUTPUT_LIMIT = 3'd5,
        REG_FILTER_ALPHA = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0]  prop_gain;
        logic [DATA_W-1:0]  integ_gain;
        logic [DATA_W-1:0]  vel_damping;
        logic [DATA_W-1:0]  feedforward_gain;
        logic [LIMIT_W-1:0] integ_limit;
        logic [LIMIT_W-1:0] output_limit;
        logic [ALPHA_W-1:0] filter_alpha;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        prop_gain:        32'd65536,
        integ_gain:       32'd0,
        vel_damping:      32'd327680,
        feedforward_gain: 32'd65536,
        integ_limit:      31'd655360,
        output_limit:     31'd1966080,
        filter_alpha:     16'd62259
    };

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic [OP_W-1:0] op_a;
        logic [OP_W-1:0] op_b;
        t_acc_op         acc_op;
    } t_mac_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_ERR,
        ST_I0,
        ST_I1,
        ST_I2,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_CMD
    } t_state;

endpackage
`default_nettype wire

// ===== design/hafp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_in_if
// Tick input channel: valid/ready plus one control tick of axis data.
// ----------------------------------------------------------------------------
interface hafp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 force_mode;
    logic signed [hafp_pkg::DATA_W-1:0]   raw_force;
    logic                                 raw_valid;
    logic signed [hafp_pkg::DATA_W-1:0]   target_force;
    logic signed [hafp_pkg::DATA_W-1:0]   axis_velocity;
    logic        [hafp_pkg::PERIOD_W-1:0] tick_period;

    modport source (
        output valid, force_mode, raw_force, raw_valid, target_force,
               axis_velocity, tick_period,
        input  ready
    );
    modport sink (
        input  valid, force_mode, raw_force, raw_valid, target_force,
               axis_velocity, tick_period,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/hafp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_out_if
// Command output channel: valid/ready plus the wrench and status flags.
// ----------------------------------------------------------------------------
interface hafp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [hafp_pkg::DATA_W-1:0] wrench_out;
    logic                               force_active;
    logic                               output_clipped;

    modport source (
        output valid, wrench_out, force_active, output_clipped,
        input  ready
    );
    modport sink (
        input  valid, wrench_out, force_active, output_clipped,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/hafp_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_cfg_if
// Configuration write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
interface hafp_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [hafp_pkg::REG_IDX_W-1:0]        index;
    logic [hafp_pkg::DATA_W-1:0]           data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/hafp_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_cfg_regs
// Gain, limit and filter registers, written one beat at a time by index.
// ----------------------------------------------------------------------------
module hafp_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    hafp_cfg_if.sink           i_cfg,
    output hafp_pkg::t_cfg     o_cfg
);

    hafp_pkg::t_cfg r_cfg;
    hafp_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                hafp_pkg::REG_PROP_GAIN:    n_cfg.prop_gain        = i_cfg.data;
                hafp_pkg::REG_INTEG_GAIN:   n_cfg.integ_gain       = i_cfg.data;
                hafp_pkg::REG_VEL_DAMPING:  n_cfg.vel_damping      = i_cfg.data;
                hafp_pkg::REG_FF_GAIN:      n_cfg.feedforward_gain = i_cfg.data;
                hafp_pkg::REG_INTEG_LIMIT:
                    n_cfg.integ_limit  = i_cfg.data[hafp_pkg::LIMIT_W-1:0];
                hafp_pkg::REG_OUTPUT_LIMIT:
                    n_cfg.output_limit = i_cfg.data[hafp_pkg::LIMIT_W-1:0];
                hafp_pkg::REG_FILTER_ALPHA:
                    n_cfg.filter_alpha = i_cfg.data[hafp_pkg::ALPHA_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= hafp_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ===== design/hafp_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_mac
// Shared signed 33x33 multiplier with a registered product and a wide
// accumulator that holds, loads, adds or subtracts the previous cycle's product.
// ----------------------------------------------------------------------------
module hafp_mac (
    input  wire logic                               i_clk,
    input  wire hafp_pkg::t_mac_req                 i_req,
    output logic signed [hafp_pkg::ACC_W-1:0]       o_acc
);

    logic signed [hafp_pkg::OP_W-1:0]   w_a;
    logic signed [hafp_pkg::OP_W-1:0]   w_b;
    logic signed [hafp_pkg::PROD_W-1:0] r_prod;
    logic signed [hafp_pkg::ACC_W-1:0]  w_prod_ext;
    logic signed [hafp_pkg::ACC_W-1:0]  r_acc;
    logic signed [hafp_pkg::ACC_W-1:0]  n_acc;

    assign w_a        = $signed(i_req.op_a);
    assign w_b        = $signed(i_req.op_b);
    assign w_prod_ext = hafp_pkg::ACC_W'(r_prod);
    assign o_acc      = r_acc;

    always_comb begin
        unique case (i_req.acc_op)
            hafp_pkg::ACC_HOLD: n_acc = r_acc;
            hafp_pkg::ACC_LOAD: n_acc = w_prod_ext;
            hafp_pkg::ACC_ADD:  n_acc = r_acc + w_prod_ext;
            hafp_pkg::ACC_SUB:  n_acc = r_acc - w_prod_ext;
            default:            n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        r_acc  <= n_acc;
    end

endmodule
`default_nettype wire

// ===== design/hafp_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_seq
// Tick sequencer: holds the loop state (filter, integral, mode), steps the
// shared multiply-accumulate unit through filter, integral and command
// products, and keeps the output register.
// ----------------------------------------------------------------------------
module hafp_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    hafp_in_if.sink                            i_in,
    hafp_out_if.source                         o_res,
    input  wire hafp_pkg::t_cfg                i_cfg,
    output hafp_pkg::t_mac_req                 o_mac,
    input  wire logic signed [hafp_pkg::ACC_W-1:0] i_acc
);

    localparam int unsigned DW    = hafp_pkg::DATA_W;
    localparam int unsigned AW    = hafp_pkg::ACC_W;
    localparam int unsigned CMD_W = AW - 16;
    localparam int unsigned INT_W = DW + 2;
    localparam logic signed [AW-1:0] RND_Q16 = AW'(32768);
    localparam logic signed [AW-1:0] RND_Q24 = AW'(8388608);
    localparam logic signed [DW-1:0] S32_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S32_MIN = {1'b1, {(DW-1){1'b0}}};

    hafp_pkg::t_state r_state, n_state;

    logic                                 r_filt_rdy, n_filt_rdy;
    logic                                 r_prev_mode, n_prev_mode;
    logic                                 r_active, n_active;
    logic signed [DW-1:0]                 r_filt, n_filt;
    logic signed [DW-1:0]                 r_integ, n_integ;
    logic signed [DW-1:0]                 r_err, n_err;
    logic signed [DW-1:0]                 r_sample, n_sample;
    logic signed [DW-1:0]                 r_target, n_target;
    logic signed [DW-1:0]                 r_vel, n_vel;
    logic        [hafp_pkg::PERIOD_W-1:0] r_period, n_period;

    logic                                 r_o_valid, n_o_valid;
    logic signed [DW-1:0]                 r_o_wrench, n_o_wrench;
    logic                                 r_o_active, n_o_active;
    logic                                 r_o_clip, n_o_clip;

    logic        [hafp_pkg::ALPHA_W:0]    w_alpha;
    logic        [hafp_pkg::ALPHA_W:0]    w_alpha_c;
    logic        [hafp_pkg::PERIOD_W-1:0] w_period;
    logic signed [AW-1:0]                 w_rnd16;
    logic signed [AW-1:0]                 w_rnd24;
    logic signed [DW:0]                   w_diff;
    logic signed [DW-1:0]                 w_err_sat;
    logic signed [DW-1:0]                 w_incr;
    logic signed [INT_W-1:0]              w_int_sum;
    logic signed [INT_W-1:0]              w_ilim;
    logic signed [CMD_W-1:0]              w_cmd;
    logic signed [CMD_W-1:0]              w_olim;
    logic                                 w_accept;
    logic                                 w_out_free;

    // alpha saturated to 0.999, period floored at one lsb
    assign w_alpha   = (i_cfg.filter_alpha > hafp_pkg::ALPHA_MAX[hafp_pkg::ALPHA_W-1:0])
                       ? hafp_pkg::ALPHA_MAX : {1'b0, i_cfg.filter_alpha};
    assign w_alpha_c = hafp_pkg::ALPHA_ONE - w_alpha;
    assign w_period  = (r_period == '0) ? hafp_pkg::PERIOD_W'(1) : r_period;

    assign w_rnd16   = i_acc + RND_Q16;
    assign w_rnd24   = i_acc + RND_Q24;

    assign w_diff    = (DW+1)'(r_target) - (DW+1)'(r_filt);
    assign w_err_sat = (w_diff[DW] != w_diff[DW-1])
                       ? (w_diff[DW] ? S32_MIN : S32_MAX) : w_diff[DW-1:0];

    assign w_incr    = $signed(w_rnd24[DW+23:24]);
    assign w_int_sum = INT_W'(r_integ) + INT_W'(w_incr);
    assign w_ilim    = INT_W'(i_cfg.integ_limit);

    assign w_cmd     = $signed(w_rnd16[AW-1:16]);
    assign w_olim    = CMD_W'(i_cfg.output_limit);

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_o_valid || o_res.ready;

    assign i_in.ready           = (r_state == hafp_pkg::ST_IDLE);
    assign o_res.valid          = r_o_valid;
    assign o_res.wrench_out     = r_o_wrench;
    assign o_res.force_active   = r_o_active;
    assign o_res.output_clipped = r_o_clip;

    always_comb begin
        n_state     = r_state;
        n_filt_rdy  = r_filt_rdy;
        n_prev_mode = r_prev_mode;
        n_active    = r_active;
        n_filt      = r_filt;
        n_integ     = r_integ;
        n_err       = r_err;
        n_sample    = r_sample;
        n_target    = r_target;
        n_vel       = r_vel;
        n_period    = r_period;
        n_o_valid   = r_o_valid && !o_res.ready;
        n_o_wrench  = r_o_wrench;
        n_o_active  = r_o_active;
        n_o_clip    = r_o_clip;
        o_mac       = '{op_a: '0, op_b: '0, acc_op: hafp_pkg::ACC_HOLD};

        unique case (r_state)
            hafp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_target    = i_in.target_force;
                    n_vel       = i_in.axis_velocity;
                    n_period    = i_in.tick_period;
                    n_active    = i_in.force_mode;
                    n_prev_mode = i_in.force_mode;
                    if (i_in.force_mode != r_prev_mode) begin
                        n_integ = '0;
                    end
                    if (i_in.raw_valid) begin
                        n_sample = i_in.raw_force;
                    end else begin
                        n_sample = r_filt_rdy ? r_filt : '0;
                    end
                    if (!i_in.force_mode) begin
                        n_state = hafp_pkg::ST_CMD;
                    end else if (!r_filt_rdy) begin
                        // first usable tick seeds the filter directly
                        n_filt     = i_in.raw_valid ? i_in.raw_force : '0;
                        n_filt_rdy = 1'b1;
                        n_state    = hafp_pkg::ST_ERR;
                    end else begin
                        n_state = hafp_pkg::ST_F0;
                    end
                end
            end
            hafp_pkg::ST_F0: begin
                o_mac.op_a = {{(DW-hafp_pkg::ALPHA_W){1'b0}}, w_alpha};
                o_mac.op_b = {r_filt[DW-1], r_filt};
                n_state    = hafp_pkg::ST_F1;
            end
            hafp_pkg::ST_F1: begin
                o_mac.op_a   = {{(DW-hafp_pkg::ALPHA_W){1'b0}}, w_alpha_c};
                o_mac.op_b   = {r_sample[DW-1], r_sample};
                o_mac.acc_op = hafp_pkg::ACC_LOAD;
                n_state      = hafp_pkg::ST_F2;
            end
            hafp_pkg::ST_F2: begin
                o_mac.acc_op = hafp_pkg::ACC_ADD;
                n_state      = hafp_pkg::ST_F3;
            end
            hafp_pkg::ST_F3: begin
                // convex mix, rounded half up, always fits in 32 bits
                n_filt  = w_rnd16[DW+15:16];
                n_state = hafp_pkg::ST_ERR;
            end
            hafp_pkg::ST_ERR: begin
                n_err   = w_err_sat;
                n_state = hafp_pkg::ST_I0;
            end
            hafp_pkg::ST_I0: begin
                o_mac.op_a = {{(DW+1-hafp_pkg::PERIOD_W){1'b0}}, w_period};
                o_mac.op_b = {r_err[DW-1], r_err};
                n_state    = hafp_pkg::ST_I1;
            end
            hafp_pkg::ST_I1: begin
                o_mac.acc_op = hafp_pkg::ACC_LOAD;
                n_state      = hafp_pkg::ST_I2;
            end
            hafp_pkg::ST_I2: begin
                priority if (w_int_sum > w_ilim) begin
                    n_integ = w_ilim[DW-1:0];
                end else if (w_int_sum < -w_ilim) begin
                    n_integ = DW'(-w_ilim);
                end else begin
                    n_integ = w_int_sum[DW-1:0];
                end
                n_state = hafp_pkg::ST_P0;
            end
            hafp_pkg::ST_P0: begin
                o_mac.op_a = {1'b0, i_cfg.feedforward_gain};
                o_mac.op_b = {r_target[DW-1], r_target};
                n_state    = hafp_pkg::ST_P1;
            end
            hafp_pkg::ST_P1: begin
                o_mac.op_a   = {1'b0, i_cfg.prop_gain};
                o_mac.op_b   = {r_err[DW-1], r_err};
                o_mac.acc_op = hafp_pkg::ACC_LOAD;
                n_state      = hafp_pkg::ST_P2;
            end
            hafp_pkg::ST_P2: begin
                o_mac.op_a   = {1'b0, i_cfg.integ_gain};
                o_mac.op_b   = {r_integ[DW-1], r_integ};
                o_mac.acc_op = hafp_pkg::ACC_ADD;
                n_state      = hafp_pkg::ST_P3;
            end
            hafp_pkg::ST_P3: begin
                o_mac.op_a   = {1'b0, i_cfg.vel_damping};
                o_mac.op_b   = {r_vel[DW-1], r_vel};
                o_mac.acc_op = hafp_pkg::ACC_ADD;
                n_state      = hafp_pkg::ST_P4;
            end
            hafp_pkg::ST_P4: begin
                // damping term is subtracted
                o_mac.acc_op = hafp_pkg::ACC_SUB;
                n_state      = hafp_pkg::ST_CMD;
            end
            hafp_pkg::ST_CMD: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_active = r_active;
                    n_o_clip   = 1'b0;
                    n_o_wrench = '0;
                    if (r_active) begin
                        priority if (w_cmd > w_olim) begin
                            n_o_wrench = w_olim[DW-1:0];
                            n_o_clip   = 1'b1;
                        end else if (w_cmd < -w_olim) begin
                            n_o_wrench = DW'(-w_olim);
                            n_o_clip   = 1'b1;
                        end else begin
                            n_o_wrench = w_cmd[DW-1:0];
                        end
                    end
                    n_state = hafp_pkg::ST_IDLE;
                end
            end
            default: n_state = hafp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hafp_pkg::ST_IDLE;
            r_filt_rdy  <= 1'b0;
            r_prev_mode <= 1'b0;
            r_filt      <= '0;
            r_integ     <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filt_rdy  <= n_filt_rdy;
            r_prev_mode <= n_prev_mode;
            r_filt      <= n_filt;
            r_integ     <= n_integ;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_active   <= n_active;
        r_err      <= n_err;
        r_sample   <= n_sample;
        r_target   <= n_target;
        r_vel      <= n_vel;
        r_period   <= n_period;
        r_o_wrench <= n_o_wrench;
        r_o_active <= n_o_active;
        r_o_clip   <= n_o_clip;
    end

endmodule
`default_nettype wire

// ===== design/hybrid_axis_force_pi_loop.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hybrid_axis_force_pi_loop
// Force PI controller with anti-windup for one hybrid axis, Q15.16 datapath.
//
// i_in carries one control tick per beat (mode, raw force and its validity,
// target force, velocity, period). o_res returns one command beat per tick.
// i_cfg writes the gain, limit and filter registers by index; it is always
// ready and should only be used while no tick is in flight.
// With force mode on and the filter primed, a tick steps through F0-F3, ERR,
// I0-I2, P0-P4 and CMD; the first force-mode tick skips F0-F3, and a tick
// with force mode off goes straight to CMD. The block takes one tick at a
// time; the next beat is accepted in the cycle after the command is written.
// One shared 33x33 multiply-accumulate unit forms up to seven products a tick.
// A finished command waits in the output register; a new tick is still
// accepted while it waits, and the sequencer holds its last step until the
// register frees up.
// Reset (synchronous, active low) restores the default gains and clears the
// filter, integral and mode history.
// ----------------------------------------------------------------------------
module hybrid_axis_force_pi_loop (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hafp_in_if.sink     i_in,
    hafp_out_if.source  o_res,
    hafp_cfg_if.sink    i_cfg
);

    hafp_pkg::t_cfg                       w_cfg;
    hafp_pkg::t_mac_req                   w_mac_req;
    logic signed [hafp_pkg::ACC_W-1:0]    w_acc;

    hafp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    hafp_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_mac_req),
        .o_acc (w_acc)
    );

    hafp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_res   (o_res),
        .i_cfg   (w_cfg),
        .o_mac   (w_mac_req),
        .i_acc   (w_acc)
    );

endmodule
`default_nettype wire

// ===== design/hafp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hafp_checker
// Port-level checks for the force loop, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hafp_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic signed [hafp_pkg::DATA_W-1:0] out_wrench,
    input wire logic                               out_active,
    input wire logic                               out_clipped
);

    // one tick in flight: ready drops right after an accepted beat
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again while a tick is in flight");

    // inactive beats carry a zero command and no clip flag
    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_active |-> (out_wrench == '0) && !out_clipped)
        else $error("inactive command beat is not zero");

    // stalled command beat is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_wrench)
            && $stable(out_active) && $stable(out_clipped))
        else $error("stalled command beat changed");

    // reset leaves no command pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output valid after reset");

endmodule

bind hybrid_axis_force_pi_loop hafp_checker u_hafp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_in.valid),
    .in_ready    (i_in.ready),
    .out_valid   (o_res.valid),
    .out_ready   (o_res.ready),
    .out_wrench  (o_res.wrench_out),
    .out_active  (o_res.force_active),
    .out_clipped (o_res.output_clipped)
);
`default_nettype wire

// ===== test/hybrid_axis_force_pi_loop_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_axis_force_pi_loop_tb
// Self-checking bench for the hybrid axis force PI loop. Ticks go in on the
// input channel, a cycle-free model of the filter, integral and command path
// predicts each command beat, and a checker compares every output beat with
// the oldest prediction. Directed corner cases, register corners and long
// random phases with random input gaps and random output backpressure.
// ----------------------------------------------------------------------------
module hybrid_axis_force_pi_loop_tb;
    import hafp_pkg::*;

    localparam int            Q16_ONE    = 65536;
    localparam logic [2:0]    REG_UNUSED = 3'd7;
    localparam longint        I32_MIN    = -64'sd2147483648;
    localparam longint        I32_MAX    = 64'sd2147483647;
    localparam longint        HALF_Q16   = 64'sd32768;
    localparam longint        HALF_Q24   = 64'sd8388608;
    localparam int            DRAIN_WAIT = 20;
    localparam int            PHASE_LEN  = 200;

    typedef struct {
        logic                       force_mode;
        logic signed [DATA_W-1:0]   raw_force;
        logic                       raw_valid;
        logic signed [DATA_W-1:0]   target_force;
        logic signed [DATA_W-1:0]   axis_velocity;
        logic        [PERIOD_W-1:0] tick_period;
    } tick_t;

    typedef struct {
        logic signed [DATA_W-1:0] wrench;
        logic                     active;
        logic                     clipped;
    } cmd_t;

    logic i_clk;
    logic i_rst_n;

    hafp_in_if  in_if ();
    hafp_out_if res_if ();
    hafp_cfg_if cfg_if ();

    hybrid_axis_force_pi_loop dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // controller state as the bench sees it
    t_cfg                     ctl_cfg;
    logic signed [DATA_W-1:0] filt_force;
    logic                     filt_ready;
    logic signed [DATA_W-1:0] err_integral;
    logic                     last_mode;

    cmd_t pending_cmds[$];
    int   fail_count;
    bit   idle_on;
    int   stall_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint clamp_long(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic void apply_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        case (idx)
            REG_PROP_GAIN:    ctl_cfg.prop_gain        = value;
            REG_INTEG_GAIN:   ctl_cfg.integ_gain       = value;
            REG_VEL_DAMPING:  ctl_cfg.vel_damping      = value;
            REG_FF_GAIN:      ctl_cfg.feedforward_gain = value;
            REG_INTEG_LIMIT:  ctl_cfg.integ_limit      = value[LIMIT_W-1:0];
            REG_OUTPUT_LIMIT: ctl_cfg.output_limit     = value[LIMIT_W-1:0];
            REG_FILTER_ALPHA: ctl_cfg.filter_alpha     = value[ALPHA_W-1:0];
            default: ;
        endcase
    endfunction

    // filter, error, integral and command for one tick; updates the state
    function automatic cmd_t predict_command(tick_t t);
        cmd_t               r;
        longint             sample, alpha, mix, err, period, incr, lim;
        logic signed [71:0] g_ff, g_kp, g_ki, g_kd, v_tgt, v_err, v_int, v_vel;
        logic signed [71:0] acc, cmd, olim;
        r.wrench  = '0;
        r.active  = 1'b0;
        r.clipped = 1'b0;
        if (t.force_mode != last_mode) begin
            err_integral = '0;
            last_mode    = t.force_mode;
        end
        if (!t.force_mode) return r;

        if (t.raw_valid) sample = longint'(t.raw_force);
        else if (filt_ready) sample = longint'(filt_force);
        else sample = 0;

        if (!filt_ready) begin
            filt_force = sample[DATA_W-1:0];
            filt_ready = 1'b1;
        end else begin
            alpha = longint'(ctl_cfg.filter_alpha);
            if (alpha > longint'(ALPHA_MAX)) alpha = longint'(ALPHA_MAX);
            mix = alpha * longint'(filt_force) + (Q16_ONE - alpha) * sample;
            filt_force = DATA_W'(clamp_long((mix + HALF_Q16) >>> 16, I32_MIN, I32_MAX));
        end

        err = clamp_long(longint'(t.target_force) - longint'(filt_force), I32_MIN, I32_MAX);
        period = longint'(t.tick_period);
        if (period == 0) period = 1;
        incr = (err * period + HALF_Q24) >>> 24;
        lim = longint'(ctl_cfg.integ_limit);
        err_integral = DATA_W'(clamp_long(longint'(err_integral) + incr, -lim, lim));

        g_ff  = {40'd0, ctl_cfg.feedforward_gain};
        g_kp  = {40'd0, ctl_cfg.prop_gain};
        g_ki  = {40'd0, ctl_cfg.integ_gain};
        g_kd  = {40'd0, ctl_cfg.vel_damping};
        v_tgt = t.target_force;
        v_err = err;
        v_int = err_integral;
        v_vel = t.axis_velocity;
        acc   = g_ff * v_tgt + g_kp * v_err + g_ki * v_int - g_kd * v_vel;
        cmd   = (acc + 72'sd32768) >>> 16;
        olim  = {41'd0, ctl_cfg.output_limit};
        if (cmd > olim) begin
            cmd       = olim;
            r.clipped = 1'b1;
        end else if (cmd < -olim) begin
            cmd       = -olim;
            r.clipped = 1'b1;
        end
        r.wrench = cmd[DATA_W-1:0];
        r.active = 1'b1;
        return r;
    endfunction

    function automatic tick_t mk_tick(bit mode, int raw, bit rv, int tgt, int vel, int per);
        tick_t t;
        t.force_mode    = mode;
        t.raw_force     = raw;
        t.raw_valid     = rv;
        t.target_force  = tgt;
        t.axis_velocity = vel;
        t.tick_period   = per[PERIOD_W-1:0];
        return t;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_force();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return int'($urandom_range(0, 200 * Q16_ONE)) - 100 * Q16_ONE;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 8 * Q16_ONE);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom;
            2: return 32'h7FFF_FFFF;
            default: return $urandom_range(Q16_ONE, 100 * Q16_ONE);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_alpha();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom_range(65470, 65535);
            2: return $urandom;
            default: return $urandom_range(40000, 65470);
        endcase
    endfunction

    // one tick beat; the prediction is taken at the accepting edge
    task automatic send_tick(tick_t t);
        int   gap;
        cmd_t pred;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid         <= 1'b1;
        in_if.force_mode    <= t.force_mode;
        in_if.raw_force     <= t.raw_force;
        in_if.raw_valid     <= t.raw_valid;
        in_if.target_force  <= t.target_force;
        in_if.axis_velocity <= t.axis_velocity;
        in_if.tick_period   <= t.tick_period;
        do @(posedge i_clk); while (!in_if.ready);
        pred = predict_command(t);
        pending_cmds.insert(pending_cmds.size(), pred);
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // only called once the block is idle
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_reg(idx, value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_all(logic [DATA_W-1:0] kp, logic [DATA_W-1:0] ki,
                             logic [DATA_W-1:0] kd, logic [DATA_W-1:0] ff,
                             logic [DATA_W-1:0] ilim, logic [DATA_W-1:0] olim,
                             logic [DATA_W-1:0] alpha);
        wait_results_done();
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_VEL_DAMPING, kd);
        write_reg(REG_FF_GAIN, ff);
        write_reg(REG_INTEG_LIMIT, ilim);
        write_reg(REG_OUTPUT_LIMIT, olim);
        write_reg(REG_FILTER_ALPHA, alpha);
    endtask

    // reset defaults: inactive tick, first sample, hold on bad sample, extremes
    task automatic test_defaults_directed();
        idle_on = 1'b0;
        send_tick(mk_tick(0, 32'sh7FFF_FFFF, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'hFFFFFF));
        send_tick(mk_tick(1, 32'sh1234_5678, 0, 10 * Q16_ONE, 0, 16777));
        send_tick(mk_tick(1, 5 * Q16_ONE, 1, 10 * Q16_ONE, Q16_ONE / 10, 16777));
        send_tick(mk_tick(1, -3 * Q16_ONE, 0, 10 * Q16_ONE, -Q16_ONE / 10, 16777));
        send_tick(mk_tick(1, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          24'hFFFFFF));
        send_tick(mk_tick(1, 32'sh8000_0000, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
        send_tick(mk_tick(0, 0, 1, 5 * Q16_ONE, 0, 16777));
        send_tick(mk_tick(1, 2 * Q16_ONE, 1, 4 * Q16_ONE, 0, 0));
        send_tick(mk_tick(1, 2 * Q16_ONE, 1, 4 * Q16_ONE, -1, 24'hFFFFFF));
    endtask

    // register corners: error saturation, alpha above limit, all-max, all-zero, unused index
    task automatic test_register_corners();
        idle_on = 1'b0;
        write_all(Q16_ONE, 100 * Q16_ONE, 0, Q16_ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_tick(mk_tick(1, 32'sh8000_0000, 1, 32'sh7FFF_FFFF, 0, 24'hFFFFFF));
        send_tick(mk_tick(1, 32'sh7FFF_FFFF, 1, 32'sh8000_0000, 0, 24'hFFFFFF));
        send_tick(mk_tick(1, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 0, 0));

        // limit writes with bit 31 set; alpha beyond its ceiling
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(mk_tick(1, 32'sh8000_0000, 1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          24'hFFFFFF));
        send_tick(mk_tick(1, 32'sh7FFF_FFFF, 1, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          24'hFFFFFF));
        send_tick(mk_tick(1, 0, 0, 1, -1, 1));
        send_tick(mk_tick(1, -1, 1, 0, 1, 24'h800000));

        write_all(0, 0, 0, 0, 0, 0, 65470);
        send_tick(mk_tick(1, 7 * Q16_ONE, 1, -7 * Q16_ONE, 3 * Q16_ONE, 16777));
        send_tick(mk_tick(1, 32'sh8000_0000, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));

        wait_results_done();
        write_reg(REG_UNUSED, $urandom);
        write_all(CFG_RESET.prop_gain, CFG_RESET.integ_gain, CFG_RESET.vel_damping,
                  CFG_RESET.feedforward_gain, 32'(CFG_RESET.integ_limit),
                  32'(CFG_RESET.output_limit), 32'(CFG_RESET.filter_alpha));
        send_tick(mk_tick(1, Q16_ONE, 1, 2 * Q16_ONE, Q16_ONE, 16777));
        send_tick(mk_tick(1, Q16_ONE, 1, 2 * Q16_ONE, Q16_ONE, 16777));
    endtask

    // random ticks in runs of force mode, fresh register set per phase
    task automatic test_random_phases();
        tick_t t;
        bit    run_mode;
        int    sel;
        run_mode = 1'b1;
        for (int p = 0; p < 6; p++) begin
            write_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                      rand_limit(), rand_limit(), rand_alpha());
            idle_on = (p != 2);
            for (int n = 0; n < PHASE_LEN; n++) begin
                // sender holds off until the block has drained
                if (n == PHASE_LEN / 2) wait_results_done();
                if ($urandom_range(0, run_mode ? 39 : 5) == 0) run_mode = !run_mode;
                t.force_mode   = run_mode;
                t.raw_force    = rand_force();
                t.raw_valid    = ($urandom_range(0, 9) != 0);
                t.target_force = rand_force();
                if ($urandom_range(0, 4) == 0) t.axis_velocity = $urandom;
                else t.axis_velocity = int'($urandom_range(0, 4 * Q16_ONE)) - 2 * Q16_ONE;
                sel = $urandom_range(0, 9);
                if (sel < 7) t.tick_period = PERIOD_W'($urandom_range(8000, 40000));
                else if (sel == 7) t.tick_period = '0;
                else if (sel == 8) t.tick_period = PERIOD_W'($urandom);
                else t.tick_period = PERIOD_W'($urandom_range(1, 100));
                send_tick(t);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_cmd
        cmd_t exp_cmd;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_cmds.size() == 0) begin
                $error("command beat with no tick outstanding: wrench_out %0d",
                       res_if.wrench_out);
                fail_count++;
            end else begin
                exp_cmd = pending_cmds.pop_front();
                if (res_if.wrench_out !== exp_cmd.wrench) begin
                    $error("wrench_out mismatch: expected %0d, got %0d",
                           exp_cmd.wrench, res_if.wrench_out);
                    fail_count++;
                end
                if (res_if.force_active !== exp_cmd.active) begin
                    $error("force_active mismatch: expected %0b, got %0b",
                           exp_cmd.active, res_if.force_active);
                    fail_count++;
                end
                if (res_if.output_clipped !== exp_cmd.clipped) begin
                    $error("output_clipped mismatch: expected %0b, got %0b",
                           exp_cmd.clipped, res_if.output_clipped);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count          = 0;
        idle_on             = 1'b0;
        stall_left          = 0;
        ctl_cfg             = CFG_RESET;
        filt_force          = '0;
        filt_ready          = 1'b0;
        err_integral        = '0;
        last_mode           = 1'b0;
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.force_mode    = 1'b0;
        in_if.raw_force     = '0;
        in_if.raw_valid     = 1'b0;
        in_if.target_force  = '0;
        in_if.axis_velocity = '0;
        in_if.tick_period   = '0;
        res_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_defaults_directed();
        test_register_corners();
        test_random_phases();

        wait_results_done();
        if (pending_cmds.size() != 0) begin
            $error("%0d command beats never arrived", pending_cmds.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/hafp_pkg.sv
design/hafp_in_if.sv
design/hafp_out_if.sv
design/hafp_cfg_if.sv
design/hafp_cfg_regs.sv
design/hafp_mac.sv
design/hafp_seq.sv
design/hybrid_axis_force_pi_loop.sv
design/hafp_checker.sv
test/hybrid_axis_force_pi_loop_tb.sv
